/* design/pd_passivity_velocity_channel_core_defines.svh */
// assertion macros for the pd passivity velocity channel
`ifndef PD_PASSIVITY_VELOCITY_CHANNEL_CORE_DEFINES_SVH
`define PD_PASSIVITY_VELOCITY_CHANNEL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PPV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPV_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPV_ASSERT(label, clk, rst_n, prop, msg)
`define PPV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* design/ppv_pkg.sv */
package ppv_pkg;

  localparam int DataW = 32;
  localparam int PGainW = 31;
  localparam int ScaleW = 17;
  localparam int CfgIdxW = 2;
  localparam int NumAxes = 3;
  localparam int DivSteps = 64;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VEL_SCALE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PASS_EN = 2'd3;

  localparam logic [PGainW-1:0] PROP_GAIN_RST = 31'd6554;
  localparam logic [PGainW-1:0] DERIV_GAIN_RST = 31'd655;
  localparam logic [ScaleW-1:0] VEL_SCALE_RST = 17'd32768;

  // datapath operations, one per step of the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_SCALE,
    OP_POS,
    OP_ERR,
    OP_PMUL,
    OP_DMUL,
    OP_FORCE,
    OP_POWER,
    OP_ENERGY,
    OP_CHECK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_CORR_ENERGY,
    OP_NEXT_AXIS
  } ppv_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SCALE,
    ST_POS,
    ST_ERR,
    ST_PMUL,
    ST_DMUL,
    ST_FORCE,
    ST_POWER,
    ST_ENERGY,
    ST_CHECK,
    ST_DIV,
    ST_DIV_DONE,
    ST_NEXT,
    ST_OUT
  } ppv_state_t;

  typedef struct packed {
    ppv_op_t op;
    logic    corr;      // second pass of the force after correction
  } ppv_cmd_t;

  typedef struct packed {
    logic corr_needed;
    logic div_done;
    logic last_axis;
  } ppv_status_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] mx;
    logic signed [95:0] mn;
    mx = 96'sh7FFF_FFFF;
    mn = -96'sh8000_0000;
    if (v > mx) sat32 = 32'sh7FFF_FFFF;
    else if (v < mn) sat32 = 32'sh8000_0000;
    else sat32 = v[DataW-1:0];
  endfunction

  // add half lsb, arithmetic shift by 16
  function automatic logic signed [79:0] qround(input logic signed [63:0] p);
    logic signed [79:0] t;
    t = 80'(p) + 80'sd32768;
    qround = t >>> 16;
  endfunction

endpackage

/* design/ppv_datapath.sv */
module ppv_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppv_pkg::ppv_cmd_t             cmd,
  output ppv_pkg::ppv_status_t          status,
  input  logic                          in_take,
  input  logic signed [31:0]            in_inc_x,
  input  logic signed [31:0]            in_inc_y,
  input  logic signed [31:0]            in_inc_z,
  input  logic signed [31:0]            in_ref_energy_x,
  input  logic signed [31:0]            in_ref_energy_y,
  input  logic signed [31:0]            in_ref_energy_z,
  input  logic [30:0]                   prop_gain,
  input  logic [30:0]                   deriv_gain,
  input  logic [16:0]                   vel_scale,
  input  logic                          pass_en,
  input  logic                          out_load,
  output logic signed [31:0]            out_force_x,
  output logic signed [31:0]            out_force_y,
  output logic signed [31:0]            out_force_z,
  output logic signed [31:0]            out_in_energy_x,
  output logic signed [31:0]            out_in_energy_y,
  output logic signed [31:0]            out_in_energy_z,
  output logic [2:0]                    out_correction_mask
);
  import ppv_pkg::*;

  logic signed [DataW-1:0] dpos_r [NumAxes];
  logic signed [DataW-1:0] apos_r [NumAxes];
  logic signed [DataW-1:0] avel_r [NumAxes];
  logic signed [DataW-1:0] ien_r [NumAxes];
  logic signed [DataW-1:0] oen_r [NumAxes];
  logic signed [DataW-1:0] inc_r [NumAxes];
  logic signed [DataW-1:0] ref_r [NumAxes];
  logic signed [DataW-1:0] force_r [NumAxes];
  logic [1:0] axis_r;
  logic signed [DataW-1:0] v_r, err_r, prev_pos_r, prev_out_r, frc_r;
  logic signed [63:0] prod_r, pmul_r, dmul_r;
  logic [2:0] mask_r;
  // restoring divider on magnitudes
  logic [63:0] quo_r, rem_r, dvd_r;
  logic [31:0] dvs_r;
  logic neg_r;
  logic [6:0] dcnt_r;

  logic signed [DataW-1:0] dpos_cur, apos_cur, avel_cur, ien_cur, oen_cur;
  logic signed [DataW-1:0] inc_cur, ref_cur;
  logic signed [79:0] pr_q, dr_q;
  logic signed [32:0] budget;
  logic signed [63:0] budget_sh;
  logic [64:0] rem_try;
  logic [63:0] quo_s;

  assign dpos_cur = dpos_r[axis_r];
  assign apos_cur = apos_r[axis_r];
  assign avel_cur = avel_r[axis_r];
  assign ien_cur  = ien_r[axis_r];
  assign oen_cur  = oen_r[axis_r];
  assign inc_cur  = inc_r[axis_r];
  assign ref_cur  = ref_r[axis_r];
  assign pr_q = qround(pmul_r);
  assign dr_q = qround(dmul_r);
  assign budget = 33'(ref_cur) + 33'(prev_out_r);
  assign budget_sh = 64'(budget) <<< 16;
  assign rem_try = {rem_r, dvd_r[63]} - 65'(dvs_r);
  assign quo_s = neg_r ? (~quo_r + 64'd1) : quo_r;

  assign status.corr_needed = pass_en && (frc_r != '0) &&
                              ((33'(ref_cur) + 33'(oen_cur)) < 0);
  assign status.div_done = (dcnt_r == 7'(DivSteps));
  assign status.last_axis = (axis_r == 2'(NumAxes - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumAxes; i++) begin
        dpos_r[i] <= '0;
        apos_r[i] <= '0;
        avel_r[i] <= '0;
        ien_r[i]  <= '0;
        oen_r[i]  <= '0;
      end
      axis_r <= '0;
      mask_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (in_take) begin
        inc_r[0] <= in_inc_x; inc_r[1] <= in_inc_y; inc_r[2] <= in_inc_z;
        ref_r[0] <= in_ref_energy_x; ref_r[1] <= in_ref_energy_y;
        ref_r[2] <= in_ref_energy_z;
        axis_r <= '0;
        mask_r <= '0;
      end
      unique case (cmd.op)
        OP_SAMPLE: begin
          for (int i = 0; i < NumAxes; i++) begin
            avel_r[i] <= inc_r[i];
            apos_r[i] <= sat32(96'(apos_r[i]) + 96'(inc_r[i]));
          end
        end
        OP_SCALE: begin
          prev_pos_r <= dpos_cur;
          prev_out_r <= oen_cur;
          prod_r <= 64'($signed({1'b0, vel_scale})) * 64'(inc_cur);
        end
        OP_POS: begin
          v_r <= sat32(96'(qround(prod_r)));
          dpos_r[axis_r] <= sat32(96'(dpos_cur) + 96'(sat32(96'(qround(prod_r)))));
        end
        OP_ERR: err_r <= sat32(96'(dpos_cur) - 96'(apos_cur));
        OP_PMUL: pmul_r <= 64'($signed({1'b0, prop_gain})) * 64'(err_r);
        OP_DMUL: dmul_r <= 64'($signed({1'b0, deriv_gain})) * 64'(avel_cur);
        OP_FORCE: frc_r <= sat32(96'(pr_q) - 96'(dr_q));
        OP_POWER: prod_r <= 64'(frc_r) * 64'(v_r);
        OP_ENERGY: begin
          if (cmd.corr) begin
            oen_r[axis_r] <= sat32(96'(oen_cur) - 96'(qround(prod_r)));
          end else if (prod_r < 0) begin
            ien_r[axis_r] <= sat32(96'(ien_cur) - 96'(qround(prod_r)));
          end else if (prod_r > 0) begin
            oen_r[axis_r] <= sat32(96'(oen_cur) - 96'(qround(prod_r)));
          end
        end
        OP_CHECK: ;
        OP_DIV_INIT: begin
          oen_r[axis_r] <= prev_out_r;
          mask_r[axis_r] <= 1'b1;
          neg_r <= budget_sh[63] ^ frc_r[31];
          dvd_r <= budget_sh[63] ? (~budget_sh + 64'd1) : budget_sh;
          dvs_r <= frc_r[31] ? (~frc_r + 32'd1) : frc_r;
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= '0;
        end
        OP_DIV_STEP: begin
          dvd_r <= {dvd_r[62:0], 1'b0};
          dcnt_r <= dcnt_r + 7'd1;
          if (!rem_try[64]) begin
            rem_r <= rem_try[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], dvd_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
        end
        OP_DIV_DONE: begin
          v_r <= sat32(96'($signed(quo_s)));
          dpos_r[axis_r] <= sat32(96'(prev_pos_r) + 96'(sat32(96'($signed(quo_s)))));
        end
        OP_CORR_ENERGY: ;
        OP_NEXT_AXIS: begin
          force_r[axis_r] <= frc_r;
          axis_r <= axis_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_force_x <= force_r[0];
      out_force_y <= force_r[1];
      out_force_z <= force_r[2];
      out_in_energy_x <= ien_r[0];
      out_in_energy_y <= ien_r[1];
      out_in_energy_z <= ien_r[2];
      out_correction_mask <= mask_r;
    end
  end

endmodule

/* design/ppv_ctrl.sv */
module ppv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_stall,
  output logic                 in_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_load,
  output ppv_pkg::ppv_cmd_t    cmd,
  input  ppv_pkg::ppv_status_t status
);
  import ppv_pkg::*;

  ppv_state_t state_r, state_nxt;
  logic corr_r, corr_nxt;
  logic ovalid_r, ovalid_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      corr_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      corr_r <= corr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    corr_nxt = corr_r;
    ovalid_nxt = ovalid_r && out_stall;
    out_load = 1'b0;
    cmd.op = OP_NONE;
    cmd.corr = corr_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = in_cmd ? ST_SCALE : ST_SAMPLE;
      ST_SAMPLE: begin cmd.op = OP_SAMPLE; state_nxt = ST_IDLE; end
      ST_SCALE: begin cmd.op = OP_SCALE; corr_nxt = 1'b0; state_nxt = ST_POS; end
      ST_POS: begin cmd.op = OP_POS; state_nxt = ST_ERR; end
      ST_ERR: begin cmd.op = OP_ERR; state_nxt = ST_PMUL; end
      ST_PMUL: begin cmd.op = OP_PMUL; state_nxt = ST_DMUL; end
      ST_DMUL: begin cmd.op = OP_DMUL; state_nxt = ST_FORCE; end
      ST_FORCE: begin cmd.op = OP_FORCE; state_nxt = ST_POWER; end
      ST_POWER: begin cmd.op = OP_POWER; state_nxt = ST_ENERGY; end
      ST_ENERGY: begin
        cmd.op = OP_ENERGY;
        state_nxt = corr_r ? ST_NEXT : ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op = OP_CHECK;
        state_nxt = status.corr_needed ? ST_DIV : ST_NEXT;
        if (status.corr_needed) cmd.op = OP_DIV_INIT;
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_done) begin
          cmd.op = OP_NONE;
          state_nxt = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        // corrected position, then rerun the force and energy steps
        cmd.op = OP_DIV_DONE;
        corr_nxt = 1'b1;
        state_nxt = ST_ERR;
      end
      ST_NEXT: begin
        cmd.op = OP_NEXT_AXIS;
        state_nxt = status.last_axis ? ST_OUT : ST_SCALE;
      end
      ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          out_load = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* design/pd_passivity_velocity_channel_core.sv */
// Three-axis PD position controller with passivity observer/controller, signed
// Q16.16 saturating. A sample transaction (cmd 0) is a single step; a command
// transaction (cmd 1) runs the axes one after another through a shared
// datapath, plus a pass of the 64-step restoring divider for an axis whose
// force is corrected. One transaction at a time; a finished result waits
// in the output register while the next transaction is taken.
`include "pd_passivity_velocity_channel_core_defines.svh"
module pd_passivity_velocity_channel_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic signed [31:0] in_inc_x,
  input  logic signed [31:0] in_inc_y,
  input  logic signed [31:0] in_inc_z,
  input  logic signed [31:0] in_ref_energy_x,
  input  logic signed [31:0] in_ref_energy_y,
  input  logic signed [31:0] in_ref_energy_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic signed [31:0] out_in_energy_x,
  output logic signed [31:0] out_in_energy_y,
  output logic signed [31:0] out_in_energy_z,
  output logic [2:0]  out_correction_mask,
  input  logic        cfg_we,
  input  logic [ppv_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ppv_pkg::DataW-2:0]   cfg_data
);
  import ppv_pkg::*;

  logic [PGainW-1:0] prop_gain_r, deriv_gain_r;
  logic [ScaleW-1:0] vel_scale_r;
  logic pass_en_r;
  logic in_take, out_load;
  ppv_cmd_t cmd;
  ppv_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      vel_scale_r <= VEL_SCALE_RST;
      pass_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROP_GAIN: prop_gain_r <= cfg_data;
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
        CFG_VEL_SCALE: vel_scale_r <= cfg_data[ScaleW-1:0];
        CFG_PASS_EN: pass_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ppv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .in_stall(in_stall), .in_take(in_take), .out_valid(out_valid),
    .out_stall(out_stall), .out_load(out_load), .cmd(cmd), .status(status)
  );

  ppv_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .in_take(in_take),
    .in_inc_x(in_inc_x), .in_inc_y(in_inc_y), .in_inc_z(in_inc_z),
    .in_ref_energy_x(in_ref_energy_x), .in_ref_energy_y(in_ref_energy_y),
    .in_ref_energy_z(in_ref_energy_z), .prop_gain(prop_gain_r),
    .deriv_gain(deriv_gain_r), .vel_scale(vel_scale_r), .pass_en(pass_en_r),
    .out_load(out_load), .out_force_x(out_force_x), .out_force_y(out_force_y),
    .out_force_z(out_force_z), .out_in_energy_x(out_in_energy_x),
    .out_in_energy_y(out_in_energy_y), .out_in_energy_z(out_in_energy_z),
    .out_correction_mask(out_correction_mask)
  );

  `PPV_ASSERT(a_load_free, clk, rst_n, out_load |-> (!out_valid || !out_stall), "result overwritten")
  `PPV_ASSERT(a_busy_stall, clk, rst_n, in_take |=> in_stall, "second transaction while busy")
  `PPV_ASSERT(a_load_sets_valid, clk, rst_n, out_load |=> out_valid, "result not shown")

endmodule
